// ----- design/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser package
// Shared types and character constants for the integer literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

   localparam int unsigned VAL_W = 63;
   localparam int unsigned CH_W  = 8;

   localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LOW_F  = 8'h66;
   localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [CH_W-1:0] CH_UP_F   = 8'h46;
   localparam logic [CH_W-1:0] CH_LOW_X  = 8'h78;
   localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
   localparam logic [CH_W-1:0] CH_LOW_B  = 8'h62;
   localparam logic [CH_W-1:0] CH_UP_B   = 8'h42;
   localparam logic [CH_W-1:0] CH_USCORE = 8'h5f;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_ZERO,
      MODE_DEC,
      MODE_HEX,
      MODE_BIN,
      MODE_OCT
   } mode_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_BIN,
      RADIX_OCT
   } radix_type;

   typedef enum logic [1:0] {
      ACT_SKIP,
      ACT_DIGIT,
      ACT_BAD
   } act_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_INVALID,
      STATUS_EMPTY,
      STATUS_TOO_BIG
   } status_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      status_type       status;
      logic [CH_W-1:0]  bad_char;
   } rsp_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
      act_type         act;
      logic [3:0]      digit;
      radix_type       radix;
      logic            lone_zero;
   } tok_type;

endpackage

`default_nettype wire

// ----- design/ilp_front.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser front end
// Tracks the radix prefix and classifies each character as a digit, a
// skipped character or an invalid digit for the chosen base.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ilp_pkg::req_type req_data,
   output logic                 tok_valid,
   input  wire logic            tok_ready,
   output ilp_pkg::tok_type     tok_data
);

   function automatic logic [4:0] digit_value(input logic [ilp_pkg::CH_W-1:0] c);
      logic [4:0] d;
      d = 5'd31;
      if (c inside {[ilp_pkg::CH_ZERO:ilp_pkg::CH_NINE]}) begin
         d = 5'(c - ilp_pkg::CH_ZERO);
      end else if (c inside {[ilp_pkg::CH_LOW_A:ilp_pkg::CH_LOW_F]}) begin
         d = 5'(c - ilp_pkg::CH_LOW_A) + 5'd10;
      end else if (c inside {[ilp_pkg::CH_UP_A:ilp_pkg::CH_UP_F]}) begin
         d = 5'(c - ilp_pkg::CH_UP_A) + 5'd10;
      end
      return d;
   endfunction

   function automatic logic [4:0] radix_base(input ilp_pkg::radix_type r);
      logic [4:0] b;
      case (r)
         ilp_pkg::RADIX_HEX: b = 5'd16;
         ilp_pkg::RADIX_BIN: b = 5'd2;
         ilp_pkg::RADIX_OCT: b = 5'd8;
         default:            b = 5'd10;
      endcase
      return b;
   endfunction

   ilp_pkg::mode_type  mode_ff;
   ilp_pkg::mode_type  mode_in;
   ilp_pkg::mode_type  next_mode;
   ilp_pkg::radix_type radix;
   ilp_pkg::act_type   act;
   logic               take;
   logic [4:0]         dval;
   logic               accept;

   assign req_ready = tok_ready;
   assign tok_valid = req_valid;
   assign accept    = req_valid && tok_ready;
   assign dval      = digit_value(req_data.ch);

   always_comb begin
      next_mode = mode_ff;
      take      = 1'b0;
      radix     = ilp_pkg::RADIX_DEC;
      case (mode_ff)
         ilp_pkg::MODE_START: begin
            if (req_data.ch == ilp_pkg::CH_ZERO) begin
               next_mode = ilp_pkg::MODE_ZERO;
            end else begin
               next_mode = ilp_pkg::MODE_DEC;
               take      = 1'b1;
            end
         end
         ilp_pkg::MODE_ZERO: begin
            if (req_data.ch == ilp_pkg::CH_LOW_X || req_data.ch == ilp_pkg::CH_UP_X) begin
               next_mode = ilp_pkg::MODE_HEX;
            end else if (req_data.ch == ilp_pkg::CH_LOW_B ||
                         req_data.ch == ilp_pkg::CH_UP_B) begin
               next_mode = ilp_pkg::MODE_BIN;
            end else begin
               next_mode = ilp_pkg::MODE_OCT;
               take      = 1'b1;
               radix     = ilp_pkg::RADIX_OCT;
            end
         end
         ilp_pkg::MODE_DEC: begin
            take = 1'b1;
         end
         ilp_pkg::MODE_HEX: begin
            take  = 1'b1;
            radix = ilp_pkg::RADIX_HEX;
         end
         ilp_pkg::MODE_BIN: begin
            take  = 1'b1;
            radix = ilp_pkg::RADIX_BIN;
         end
         ilp_pkg::MODE_OCT: begin
            take  = 1'b1;
            radix = ilp_pkg::RADIX_OCT;
         end
         default: begin
            next_mode = ilp_pkg::MODE_START;
         end
      endcase

      act = ilp_pkg::ACT_SKIP;
      if (take && req_data.ch != ilp_pkg::CH_USCORE) begin
         if (dval < radix_base(radix)) begin
            act = ilp_pkg::ACT_DIGIT;
         end else begin
            act = ilp_pkg::ACT_BAD;
         end
      end

      mode_in = mode_ff;
      if (accept) begin
         mode_in = req_data.last ? ilp_pkg::MODE_START : next_mode;
      end
   end

   always_comb begin
      tok_data.ch        = req_data.ch;
      tok_data.last      = req_data.last;
      tok_data.act       = act;
      tok_data.digit     = dval[3:0];
      tok_data.radix     = radix;
      tok_data.lone_zero = (next_mode == ilp_pkg::MODE_ZERO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ilp_pkg::MODE_START;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ilp_queue.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser token queue
// Two-entry register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire ilp_pkg::tok_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output ilp_pkg::tok_type      out_data
);

   ilp_pkg::tok_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ilp_back.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser back end
// Accumulates digits with a shift-and-add, tracks the error flags and
// registers one result at the last character of each literal.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_back #(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             tok_valid,
   output logic                  tok_ready,
   input  wire ilp_pkg::tok_type tok_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ilp_pkg::rsp_type      rsp_data
);

   localparam int unsigned AW = VALUE_WIDTH - 1;
   localparam int unsigned PW = AW + 5;
   localparam logic [PW-1:0] LIMIT = {{5{1'b0}}, {AW{1'b1}}};

   logic [AW-1:0]          acc_ff;
   logic [AW-1:0]          acc_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic                   inv_ff;
   logic                   inv_in;
   logic [ilp_pkg::CH_W-1:0] bad_ff;
   logic [ilp_pkg::CH_W-1:0] bad_in;
   logic                   seen_ff;
   logic                   seen_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   ilp_pkg::rsp_type       rsp_ff;
   ilp_pkg::rsp_type       rsp_in;
   logic                   pop;
   logic [PW-1:0]          acc_x;
   logic [PW-1:0]          scaled;
   logic [PW-1:0]          sum;
   logic [AW-1:0]          acc_n;
   logic                   ovf_n;
   logic                   inv_n;
   logic [ilp_pkg::CH_W-1:0] bad_n;
   logic                   seen_n;

   assign tok_ready = !tok_data.last || !rsp_valid_ff || rsp_ready;
   assign pop       = tok_valid && tok_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign acc_x     = {{5{1'b0}}, acc_ff};

   always_comb begin
      case (tok_data.radix)
         ilp_pkg::RADIX_HEX: scaled = acc_x << 4;
         ilp_pkg::RADIX_BIN: scaled = acc_x << 1;
         ilp_pkg::RADIX_OCT: scaled = acc_x << 3;
         default:            scaled = (acc_x << 3) + (acc_x << 1);
      endcase
      sum = scaled + {{(PW-4){1'b0}}, tok_data.digit};
   end

   always_comb begin
      acc_n  = acc_ff;
      ovf_n  = ovf_ff;
      inv_n  = inv_ff;
      bad_n  = bad_ff;
      seen_n = seen_ff;
      case (tok_data.act)
         ilp_pkg::ACT_DIGIT: begin
            seen_n = 1'b1;
            if (!ovf_ff) begin
               if (sum > LIMIT) begin
                  ovf_n = 1'b1;
               end else begin
                  acc_n = sum[AW-1:0];
               end
            end
         end
         ilp_pkg::ACT_BAD: begin
            if (!inv_ff) begin
               inv_n = 1'b1;
               bad_n = tok_data.ch;
            end
         end
         default: begin
         end
      endcase

      rsp_in.value    = '0;
      rsp_in.status   = ilp_pkg::STATUS_OK;
      rsp_in.bad_char = '0;
      if (tok_data.lone_zero) begin
         rsp_in.status = ilp_pkg::STATUS_OK;
      end else if (inv_n) begin
         rsp_in.status   = ilp_pkg::STATUS_INVALID;
         rsp_in.bad_char = bad_n;
      end else if (!seen_n) begin
         rsp_in.status = ilp_pkg::STATUS_EMPTY;
      end else if (ovf_n) begin
         rsp_in.status = ilp_pkg::STATUS_TOO_BIG;
      end else begin
         rsp_in.value = ilp_pkg::VAL_W'(acc_n);
      end

      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      inv_in  = inv_ff;
      bad_in  = bad_ff;
      seen_in = seen_ff;
      if (pop) begin
         if (tok_data.last) begin
            acc_in  = '0;
            ovf_in  = 1'b0;
            inv_in  = 1'b0;
            bad_in  = '0;
            seen_in = 1'b0;
         end else begin
            acc_in  = acc_n;
            ovf_in  = ovf_n;
            inv_in  = inv_n;
            bad_in  = bad_n;
            seen_in = seen_n;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop && tok_data.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && tok_data.last) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         inv_ff       <= 1'b0;
         bad_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         inv_ff       <= inv_in;
         bad_ff       <= bad_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/integer_literal_parser_core.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser core
// Parses an integer literal given one character per word on the req_
// channel, with last set on the final character. The base follows the
// prefix: 0x or 0X for hex, 0b or 0B for binary, any other text after a
// leading zero for octal, decimal otherwise. Underscores are skipped.
// One word leaves on the rsp_ channel per literal, with the value, a status
// (ok, invalid digit, no digits, too big) and the first rejected character.
// Throughput is one character per cycle unless the receiver stalls, set
// by the combinational shift-and-add of the accumulator in the back end.
// A result is registered onto rsp_ as the back end takes a last character.
// When the receiver stalls, the back end holds the next last character
// while the two-entry queue keeps taking characters until it is full.
// Reset clears the prefix state, the accumulator, the flags and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_parser_core #(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ilp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ilp_pkg::rsp_type      rsp_data
);

   logic             front_valid;
   logic             front_ready;
   ilp_pkg::tok_type front_tok;
   logic             back_valid;
   logic             back_ready;
   ilp_pkg::tok_type back_tok;

   ilp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tok_valid (front_valid),
      .tok_ready (front_ready),
      .tok_data  (front_tok)
   );

   ilp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_tok),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_tok)
   );

   ilp_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (back_valid),
      .tok_ready (back_ready),
      .tok_data  (back_tok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser core testbench
// Feeds literals one character per word: a few fixed cases (lone zero, bare
// prefixes, underscores, mixed-case hex, bad digits), values around the
// signed 64-bit limit in random bases, a long receiver hold-off that backs
// up the input, and a random mix of well-formed, broken and junk literals.
// A local parser computes each expected result word, which is compared
// field by field with the word that leaves the core.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned VALUE_WIDTH   = 64;
   localparam logic [63:0] VALUE_LIMIT   = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam int unsigned BASE_BIN      = 2;
   localparam int unsigned BASE_OCT      = 8;
   localparam int unsigned BASE_DEC      = 10;
   localparam int unsigned BASE_HEX      = 16;
   localparam int unsigned RANDOM_CHARS  = 280;
   localparam int unsigned LIMIT_CASES   = 4;
   localparam int unsigned HOLD_LITERALS = 16;
   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned TIMEOUT_NS    = 10_000_000;

   typedef logic [ilp_pkg::CH_W-1:0] char_type;
   typedef char_type char_queue_type[$];

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ilp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ilp_pkg::rsp_type rsp_data;

   ilp_pkg::rsp_type parsed_literals[$];
   int unsigned char_count      = 0;
   int unsigned mismatch_count  = 0;
   int unsigned hold_off_cycles = 0;
   bit          quiet_phase     = 1'b0;

   ilp_pkg::mode_type lit_mode;
   logic [63:0]       lit_acc;
   logic              lit_overflow;
   logic              lit_invalid;
   logic              lit_digit;
   char_type          lit_bad;

   integer_literal_parser_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_literal();
      lit_mode     = ilp_pkg::MODE_START;
      lit_acc      = '0;
      lit_overflow = 1'b0;
      lit_invalid  = 1'b0;
      lit_digit    = 1'b0;
      lit_bad      = '0;
   endfunction

   function automatic int unsigned digit_value(char_type c);
      if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE)
         return int'(c - ilp_pkg::CH_ZERO);
      if (c >= ilp_pkg::CH_LOW_A && c <= ilp_pkg::CH_LOW_F)
         return int'(c - ilp_pkg::CH_LOW_A) + 10;
      if (c >= ilp_pkg::CH_UP_A && c <= ilp_pkg::CH_UP_F)
         return int'(c - ilp_pkg::CH_UP_A) + 10;
      return 255;
   endfunction

   function automatic void take_digit(int unsigned base, char_type c);
      int unsigned d;
      if (c == ilp_pkg::CH_USCORE) return;
      d = digit_value(c);
      if (d >= base) begin
         if (!lit_invalid) begin
            lit_invalid = 1'b1;
            lit_bad     = c;
         end
         return;
      end
      lit_digit = 1'b1;
      if (lit_overflow) return;
      if (lit_acc > (VALUE_LIMIT - 64'(d)) / 64'(base)) begin
         lit_overflow = 1'b1;
         return;
      end
      lit_acc = lit_acc * 64'(base) + 64'(d);
   endfunction

   function automatic void parse_char(char_type c, logic last);
      ilp_pkg::rsp_type word;
      case (lit_mode)
         ilp_pkg::MODE_START: begin
            if (c == ilp_pkg::CH_ZERO) begin
               lit_mode = ilp_pkg::MODE_ZERO;
            end else begin
               lit_mode = ilp_pkg::MODE_DEC;
               take_digit(BASE_DEC, c);
            end
         end
         ilp_pkg::MODE_ZERO: begin
            if (c == ilp_pkg::CH_LOW_X || c == ilp_pkg::CH_UP_X) begin
               lit_mode = ilp_pkg::MODE_HEX;
            end else if (c == ilp_pkg::CH_LOW_B || c == ilp_pkg::CH_UP_B) begin
               lit_mode = ilp_pkg::MODE_BIN;
            end else begin
               lit_mode = ilp_pkg::MODE_OCT;
               take_digit(BASE_OCT, c);
            end
         end
         ilp_pkg::MODE_DEC: take_digit(BASE_DEC, c);
         ilp_pkg::MODE_HEX: take_digit(BASE_HEX, c);
         ilp_pkg::MODE_BIN: take_digit(BASE_BIN, c);
         ilp_pkg::MODE_OCT: take_digit(BASE_OCT, c);
         default: clear_literal();
      endcase
      if (!last) return;
      word = '0;
      if (lit_mode == ilp_pkg::MODE_ZERO) begin
         word.status = ilp_pkg::STATUS_OK;
      end else if (lit_invalid) begin
         word.status   = ilp_pkg::STATUS_INVALID;
         word.bad_char = lit_bad;
      end else if (!lit_digit) begin
         word.status = ilp_pkg::STATUS_EMPTY;
      end else if (lit_overflow) begin
         word.status = ilp_pkg::STATUS_TOO_BIG;
      end else begin
         word.status = ilp_pkg::STATUS_OK;
         word.value  = lit_acc[ilp_pkg::VAL_W-1:0];
      end
      parsed_literals.push_back(word);
      clear_literal();
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic char_type digit_char(int unsigned d, bit upper);
      if (d < 10) return ilp_pkg::CH_ZERO + char_type'(d);
      return (upper ? ilp_pkg::CH_UP_A : ilp_pkg::CH_LOW_A) + char_type'(d - 10);
   endfunction

   function automatic char_queue_type radix_prefix(int unsigned base);
      char_queue_type text;
      if (base != BASE_DEC) text.push_back(ilp_pkg::CH_ZERO);
      if (base == BASE_HEX)
         text.push_back($urandom_range(0, 1) ? ilp_pkg::CH_UP_X : ilp_pkg::CH_LOW_X);
      if (base == BASE_BIN)
         text.push_back($urandom_range(0, 1) ? ilp_pkg::CH_UP_B : ilp_pkg::CH_LOW_B);
      return text;
   endfunction

   function automatic int unsigned random_base();
      case ($urandom_range(0, 3))
         0: return BASE_DEC;
         1: return BASE_HEX;
         2: return BASE_BIN;
         default: return BASE_OCT;
      endcase
   endfunction

   function automatic char_queue_type text_chars(string s);
      char_queue_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      return text;
   endfunction

   function automatic char_queue_type number_literal(logic [63:0] v, int unsigned base);
      char_queue_type digits;
      char_queue_type text;
      bit             upper;
      upper = 1'($urandom_range(0, 1));
      do begin
         digits.push_front(digit_char(int'(v % 64'(base)), upper));
         v = v / 64'(base);
      end while (v != 0);
      text = radix_prefix(base);
      foreach (digits[i]) text.push_back(digits[i]);
      return text;
   endfunction

   function automatic char_queue_type random_literal();
      int unsigned    base;
      int unsigned    ndig;
      int unsigned    maxdig;
      char_queue_type text;
      base   = random_base();
      maxdig = (base == BASE_BIN) ? 66 : (base == BASE_OCT) ? 23 :
               (base == BASE_HEX) ? 17 : 21;
      ndig   = ($urandom_range(0, 9) == 0) ? $urandom_range(maxdig - 3, maxdig)
                                           : $urandom_range(1, 6);
      text   = radix_prefix(base);
      for (int i = 0; i < ndig; i++) begin
         if ($urandom_range(0, 9) == 0) text.push_back(ilp_pkg::CH_USCORE);
         if (base == BASE_DEC && i == 0)
            text.push_back(digit_char($urandom_range(1, 9), 1'b0));
         else
            text.push_back(digit_char($urandom_range(0, base - 1),
                                      1'($urandom_range(0, 1))));
      end
      return text;
   endfunction

   task automatic send_char(input char_type c, input logic last);
      int unsigned      gap;
      ilp_pkg::req_type item;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.ch   = c;
      item.last = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      parse_char(c, last);
      char_count++;
   endtask

   task automatic send_literal(input char_queue_type text);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic test_directed();
      char_queue_type one;
      send_literal(text_chars("0"));
      send_literal(text_chars("0x"));
      send_literal(text_chars("0_"));
      send_literal(text_chars("_"));
      send_literal(text_chars("0b1"));
      send_literal(text_chars("0Xf_A"));
      send_literal(text_chars("0B"));
      send_literal(text_chars("08"));
      send_literal(text_chars("12a"));
      send_literal(text_chars("7"));
      one.push_back(8'hff);
      send_literal(one);
      one[0] = 8'h00;
      send_literal(one);
   endtask

   task automatic test_range_limits();
      logic [63:0] v;
      for (int i = 0; i < LIMIT_CASES; i++) begin
         v = VALUE_LIMIT - 64'd3 + 64'($urandom_range(0, 6));
         send_literal(number_literal(v, random_base()));
      end
   endtask

   task automatic test_back_pressure();
      quiet_phase     = 1'b1;
      hold_off_cycles = 80;
      for (int i = 0; i < HOLD_LITERALS; i++) send_literal(random_literal());
      quiet_phase = 1'b0;
   endtask

   task automatic test_random_literals();
      int unsigned    stop_at;
      int unsigned    kind;
      int unsigned    idx;
      char_queue_type text;
      stop_at = char_count + RANDOM_CHARS;
      while (char_count < stop_at) begin
         if ($urandom_range(0, 39) == 0) quiet_phase = !quiet_phase;
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            text = random_literal();
         end else if (kind < 80) begin
            text = random_literal();
            idx = $urandom_range(0, text.size() - 1);
            text[idx] = char_type'($urandom_range(0, 255));
         end else if (kind < 88) begin
            text = number_literal(VALUE_LIMIT - 64'd3 + 64'($urandom_range(0, 6)),
                                  random_base());
         end else begin
            text.delete();
            repeat ($urandom_range(1, 4)) text.push_back(char_type'($urandom_range(0, 255)));
         end
         send_literal(text);
      end
      quiet_phase = 1'b0;
   endtask

   initial begin : receiver
      int unsigned stall;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = idle_gap();
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      ilp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parsed_literals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("tb: unexpected word value=%0d status=%0d bad=%02h",
                        rsp_data.value, rsp_data.status, rsp_data.bad_char);
         end else begin
            want = parsed_literals.pop_front();
            if (rsp_data.value !== want.value || rsp_data.status !== want.status ||
                rsp_data.bad_char !== want.bad_char) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("tb: mismatch expected value=%0d status=%0d bad=%02h, %s",
                           want.value, want.status, want.bad_char,
                           $sformatf("got value=%0d status=%0d bad=%02h",
                                     rsp_data.value, rsp_data.status, rsp_data.bad_char));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      clear_literal();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_range_limits();
      test_back_pressure();
      test_random_literals();
      req_valid <= 1'b0;
      while (parsed_literals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && parsed_literals.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule

// ----- integer_literal_parser_core.f -----
design/ilp_pkg.sv
design/ilp_front.sv
design/ilp_queue.sv
design/ilp_back.sv
design/integer_literal_parser_core.sv
tb/tb.sv
